// ===== rtl/imu_caf_pkg.sv =====
// Shared types and constants for the IMU complementary attitude filter.
`default_nettype none
package imu_caf_pkg;
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_imu_in;

    typedef struct packed {
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_angle;
        logic signed [31:0] yaw_angle;
    } t_imu_out;

    localparam int CORDIC_FRAC = 24;
    localparam int TABLE_LEN   = 24;
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;

    localparam logic [1:0] REG_ACCEL_WEIGHT = 2'd0;
    localparam logic [1:0] REG_TILT_GAIN    = 2'd1;
    localparam logic [1:0] REG_YAW_GAIN     = 2'd2;
    localparam logic [1:0] REG_YAW_BIAS     = 2'd3;

    localparam logic [16:0] RST_ACCEL_WEIGHT = 17'd1311;
    localparam logic [31:0] RST_TILT_GAIN    = 32'd1309441;
    localparam logic [31:0] RST_YAW_GAIN     = 32'd1309441;
    localparam logic [31:0] RST_YAW_BIAS     = 32'd0;

    // atan(2^-i) in degrees, 24 fractional bits
    function automatic logic [31:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0:  atan_deg = 32'd754974720;
            5'd1:  atan_deg = 32'd445687602;
            5'd2:  atan_deg = 32'd235489088;
            5'd3:  atan_deg = 32'd119537938;
            5'd4:  atan_deg = 32'd60000934;
            5'd5:  atan_deg = 32'd30029717;
            5'd6:  atan_deg = 32'd15018523;
            5'd7:  atan_deg = 32'd7509720;
            5'd8:  atan_deg = 32'd3754917;
            5'd9:  atan_deg = 32'd1877466;
            5'd10: atan_deg = 32'd938734;
            5'd11: atan_deg = 32'd469367;
            5'd12: atan_deg = 32'd234684;
            5'd13: atan_deg = 32'd117342;
            5'd14: atan_deg = 32'd58671;
            5'd15: atan_deg = 32'd29335;
            5'd16: atan_deg = 32'd14668;
            5'd17: atan_deg = 32'd7334;
            5'd18: atan_deg = 32'd3667;
            5'd19: atan_deg = 32'd1833;
            5'd20: atan_deg = 32'd917;
            5'd21: atan_deg = 32'd458;
            5'd22: atan_deg = 32'd229;
            5'd23: atan_deg = 32'd115;
            default: atan_deg = 32'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/imu_caf_front.sv =====
// Input front end: two-entry queue of raw sample sets.
`default_nettype none
module imu_caf_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire imu_caf_pkg::t_imu_in  i_item,
    output logic                       o_valid,
    input  wire logic                  i_take,
    output imu_caf_pkg::t_imu_in       o_item
);
    import imu_caf_pkg::*;

    t_imu_in    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = push && !full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/imu_caf_cordic.sv =====
// Iterative vectoring CORDIC, atan2 in degrees, one rotation per cycle.
`default_nettype none
module imu_caf_cordic #(
    parameter int ATAN_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [15:0] i_x,
    output logic                    o_done,
    output logic signed [31:0]      o_angle
);
    import imu_caf_pkg::*;

    localparam int NIT = (ATAN_ITERATIONS < TABLE_LEN) ? ATAN_ITERATIONS : TABLE_LEN;
    localparam int SH  = CORDIC_FRAC - ANGLE_FRAC_BITS;

    // 16-bit input scaled by 2^16 and grown by the CORDIC gain: 36 bits suffice
    logic signed [35:0] r_x, r_y;
    logic signed [35:0] r_z;
    logic [4:0]         r_i;
    logic               r_busy;
    logic signed [35:0] w_xs, w_ys, w_xe, w_ye, w_zr;
    logic signed [35:0] w_tab;

    assign w_xs  = r_x >>> r_i;
    assign w_ys  = r_y >>> r_i;
    assign w_tab = $signed({4'd0, atan_deg(r_i)});
    assign w_xe  = {{20{i_x[15]}}, i_x} <<< 16;
    assign w_ye  = {{20{i_y[15]}}, i_y} <<< 16;
    assign w_zr  = (r_z + (36'sd1 <<< (SH - 1))) >>> SH;
    assign o_angle = w_zr[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_i    <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_x == 16'sd0 && i_y == 16'sd0) begin
                    r_x <= '0; r_y <= '0; r_z <= '0;
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    if (i_x < 0) begin
                        r_x <= -w_xe;
                        r_y <= -w_ye;
                        r_z <= (i_y >= 0) ? (36'sd180 <<< CORDIC_FRAC)
                                          : -(36'sd180 <<< CORDIC_FRAC);
                    end else begin
                        r_x <= w_xe;
                        r_y <= w_ye;
                        r_z <= '0;
                    end
                end
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_tab;
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_tab;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(NIT - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/imu_caf_back.sv =====
// Filter back end: sequences CORDIC, gyro terms, blends and the result register.
`default_nettype none
module imu_caf_back #(
    parameter int ATAN_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_take,
    input  wire imu_caf_pkg::t_imu_in  i_item,
    input  wire logic [16:0]           i_accel_weight,
    input  wire logic [31:0]           i_tilt_gain,
    input  wire logic [31:0]           i_yaw_gain,
    input  wire logic [31:0]           i_yaw_bias,
    output logic                       empty,
    input  wire logic                  pop,
    output imu_caf_pkg::t_imu_out      o_result
);
    import imu_caf_pkg::*;

    localparam int RSH = 32 - ANGLE_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_CP, S_WP, S_RATE, S_BLEND, S_ACC, S_SUM, S_CR, S_WR, S_YAW, S_OUT
    } t_state;

    t_state             r_state;
    t_imu_in            r_item;
    logic               r_axis;   // 0 pitch, 1 roll
    logic signed [31:0] r_pitch, r_roll, r_yaw;
    logic signed [31:0] r_acc;
    logic signed [63:0] r_prod, r_wsum;
    logic signed [49:0] r_pred;
    logic [16:0]        r_w;
    logic               r_cstart;
    logic               w_cdone;
    logic signed [31:0] w_cang;
    logic signed [15:0] w_cy;
    logic signed [63:0] w_rt, w_blend;
    logic signed [33:0] w_yaw;
    logic               r_full;
    t_imu_out           r_out;

    assign w_cy = r_axis ? r_item.accel_x : r_item.accel_y;

    imu_caf_cordic #(
        .ATAN_ITERATIONS(ATAN_ITERATIONS),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_cstart),
        .i_y(w_cy), .i_x(r_item.accel_z), .o_done(w_cdone), .o_angle(w_cang)
    );

    assign o_take   = (r_state == S_IDLE) && i_valid;
    assign empty    = !r_full;
    assign o_result = r_out;
    assign w_rt     = (r_prod + (64'sd1 <<< (RSH - 1))) >>> RSH;
    assign w_blend  = (r_wsum + 64'sd32768) >>> 16;
    assign w_yaw    = 34'(w_rt) + 34'(r_yaw) - 34'($signed(i_yaw_bias));

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > 64'sd2147483647)       sat = 32'sh7fffffff;
        else if (v < -64'sd2147483648) sat = 32'sh80000000;
        else                           sat = v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pitch  <= '0;
            r_roll   <= '0;
            r_yaw    <= '0;
            r_full   <= 1'b0;
            r_cstart <= 1'b0;
            r_axis   <= 1'b0;
        end else begin
            r_cstart <= 1'b0;
            if (pop && r_full) r_full <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_item   <= i_item;
                    r_axis   <= 1'b0;
                    r_w      <= (i_accel_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_accel_weight;
                    r_cstart <= 1'b1;
                    r_state  <= S_CP;
                end
                S_CP, S_CR: if (w_cdone) begin
                    r_acc   <= w_cang;
                    // gyro x drives pitch, gyro y drives roll
                    r_prod  <= 64'(r_axis ? r_item.gyro_y : r_item.gyro_x)
                               * $signed({1'b0, i_tilt_gain});
                    r_state <= S_RATE;
                end
                S_RATE: begin
                    r_pred  <= 50'(w_rt) + 50'(r_axis ? r_roll : r_pitch);
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    r_wsum  <= 64'(r_pred) * $signed({1'b0, WEIGHT_ONE - r_w});
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_prod  <= 64'(r_acc) * $signed({1'b0, r_w});
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_wsum  <= r_wsum + r_prod;
                    r_state <= S_WP;
                end
                S_WP: begin
                    if (r_axis) begin
                        r_roll   <= sat(w_blend);
                        r_prod   <= 64'(r_item.gyro_z) * $signed({1'b0, i_yaw_gain});
                        r_state  <= S_YAW;
                    end else begin
                        r_pitch  <= sat(w_blend);
                        r_axis   <= 1'b1;
                        r_cstart <= 1'b1;
                        r_state  <= S_CR;
                    end
                end
                S_YAW: begin
                    r_yaw   <= sat(64'(w_yaw));
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_full || pop) begin
                    r_out.pitch_angle <= r_pitch;
                    r_out.roll_angle  <= r_roll;
                    r_out.yaw_angle   <= r_yaw;
                    r_full  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/imu_complementary_attitude_filter.sv =====
// Top level of the IMU complementary attitude filter.
// A result comes sooner when an accel pair is zero and its CORDIC rotations are skipped.
// The back end takes no new sample set before it is done with the last, as its single
// CORDIC is used for pitch then roll. A two-entry input queue decouples the sides.
// Synchronous active-low reset clears angles, queues and registers to defaults.
`default_nettype none
module imu_complementary_attitude_filter #(
    parameter int ATAN_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire imu_caf_pkg::t_imu_in   i_item,
    output logic                        empty,
    input  wire logic                   pop,
    output imu_caf_pkg::t_imu_out       o_result,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import imu_caf_pkg::*;

    logic [16:0] r_accel_weight;
    logic [31:0] r_tilt_gain, r_yaw_gain, r_yaw_bias;
    logic        w_valid, w_take;
    t_imu_in     w_item;
    logic [1:0]  w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];

    // register write at the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_weight <= RST_ACCEL_WEIGHT;
            r_tilt_gain    <= RST_TILT_GAIN;
            r_yaw_gain     <= RST_YAW_GAIN;
            r_yaw_bias     <= RST_YAW_BIAS;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_ACCEL_WEIGHT: r_accel_weight <= pwdata[16:0];
                REG_TILT_GAIN:    r_tilt_gain    <= pwdata;
                REG_YAW_GAIN:     r_yaw_gain     <= pwdata;
                REG_YAW_BIAS:     r_yaw_bias     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ACCEL_WEIGHT: prdata = {15'd0, r_accel_weight};
            REG_TILT_GAIN:    prdata = r_tilt_gain;
            REG_YAW_GAIN:     prdata = r_yaw_gain;
            REG_YAW_BIAS:     prdata = r_yaw_bias;
            default:          prdata = '0;
        endcase
    end

    // front: accept and hold sample sets
    imu_caf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_item(i_item), .o_valid(w_valid), .i_take(w_take), .o_item(w_item)
    );

    // back: CORDIC, blends, yaw integration and the result register
    imu_caf_back #(
        .ATAN_ITERATIONS(ATAN_ITERATIONS),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .o_take(w_take),
        .i_item(w_item), .i_accel_weight(r_accel_weight),
        .i_tilt_gain(r_tilt_gain), .i_yaw_gain(r_yaw_gain),
        .i_yaw_bias(r_yaw_bias), .empty(empty), .pop(pop), .o_result(o_result)
    );
endmodule
`default_nettype wire

// ===== bench/imu_caf_checker.sv =====
// Checker for the attitude filter: predicts each result and compares it on transfer.
module imu_caf_checker (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic                  i_full,
    input  wire imu_caf_pkg::t_imu_in  i_item,
    input  wire logic                  i_empty,
    input  wire logic                  i_pop,
    input  wire imu_caf_pkg::t_imu_out i_result,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [3:0]            i_paddr,
    input  wire logic [31:0]           i_pwdata,
    input  wire logic                  i_pready,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import imu_caf_pkg::*;

    localparam int ITERS = 16;
    localparam int FRAC  = 16;

    logic [16:0] weight_q;
    logic [31:0] tilt_gain_q;
    logic [31:0] yaw_gain_q;
    logic [31:0] yaw_bias_q;
    logic signed [31:0] pitch_q, roll_q, yaw_q;
    t_imu_out angle_fifo[$];

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                        input int s);
        round_shift = (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            clamp32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            clamp32 = 32'sh80000000;
        else
            clamp32 = v[31:0];
    endfunction

    // Vectoring CORDIC angle in degrees with FRAC fractional bits.
    function automatic logic signed [63:0] tilt_deg(input logic signed [15:0] num,
                                                    input logic signed [15:0] den);
        logic signed [63:0] xs, ys, xn, yn, z, step;
        int k;
        if (num == 0 && den == 0)
            return 0;
        xs = 64'(den) * 65536;
        ys = 64'(num) * 65536;
        z = 0;
        if (xs < 0) begin
            z = (ys >= 0) ? 64'sd180 <<< CORDIC_FRAC : -(64'sd180 <<< CORDIC_FRAC);
            xs = -xs;
            ys = -ys;
        end
        for (k = 0; k < ITERS && k < TABLE_LEN; k++) begin
            case (k)
                0: step = 754974720;  1: step = 445687602;  2: step = 235489088;
                3: step = 119537938;  4: step = 60000934;   5: step = 30029717;
                6: step = 15018523;   7: step = 7509720;    8: step = 3754917;
                9: step = 1877466;    10: step = 938734;    11: step = 469367;
                12: step = 234684;    13: step = 117342;    14: step = 58671;
                15: step = 29335;     16: step = 14668;     17: step = 7334;
                18: step = 3667;      19: step = 1833;      20: step = 917;
                21: step = 458;       22: step = 229;       default: step = 115;
            endcase
            if (ys >= 0) begin
                xn = xs + (ys >>> k);
                yn = ys - (xs >>> k);
                z += step;
            end else begin
                xn = xs - (ys >>> k);
                yn = ys + (xs >>> k);
                z -= step;
            end
            xs = xn;
            ys = yn;
        end
        return round_shift(z, CORDIC_FRAC - FRAC);
    endfunction

    function automatic logic signed [63:0] gyro_delta(input logic signed [15:0] rate,
                                                      input logic [31:0] gain);
        return round_shift(64'(rate) * $signed({32'd0, gain}), 32 - FRAC);
    endfunction

    function automatic logic signed [31:0] fuse(input logic signed [31:0] old,
                                                input logic signed [63:0] acc,
                                                input logic signed [15:0] rate);
        logic signed [63:0] w, pred;
        w = (weight_q > WEIGHT_ONE) ? 64'sd65536 : 64'($unsigned(weight_q));
        pred = 64'(old) + gyro_delta(rate, tilt_gain_q);
        return clamp32(round_shift(w * acc + (64'sd65536 - w) * pred, 16));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_imu_out want;
        if (!i_rst_n) begin
            weight_q    <= RST_ACCEL_WEIGHT;
            tilt_gain_q <= RST_TILT_GAIN;
            yaw_gain_q  <= RST_YAW_GAIN;
            yaw_bias_q  <= RST_YAW_BIAS;
            pitch_q = 0;
            roll_q  = 0;
            yaw_q   = 0;
            angle_fifo.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_ACCEL_WEIGHT: weight_q    <= i_pwdata[16:0];
                    REG_TILT_GAIN:    tilt_gain_q <= i_pwdata;
                    REG_YAW_GAIN:     yaw_gain_q  <= i_pwdata;
                    REG_YAW_BIAS:     yaw_bias_q  <= i_pwdata;
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                pitch_q = fuse(pitch_q, tilt_deg(i_item.accel_y, i_item.accel_z),
                               i_item.gyro_x);
                roll_q = fuse(roll_q, tilt_deg(i_item.accel_x, i_item.accel_z),
                              i_item.gyro_y);
                yaw_q = clamp32(64'(yaw_q) + gyro_delta(i_item.gyro_z, yaw_gain_q)
                                - 64'($signed(yaw_bias_q)));
                angle_fifo.push_back('{pitch_q, roll_q, yaw_q});
            end
            if (i_pop && !i_empty) begin
                if (angle_fifo.size() == 0) begin
                    report_mismatch("unexpected result", i_result.pitch_angle, 0);
                end else begin
                    want = angle_fifo.pop_front();
                    if (i_result.pitch_angle !== want.pitch_angle)
                        report_mismatch("pitch", i_result.pitch_angle, want.pitch_angle);
                    if (i_result.roll_angle !== want.roll_angle)
                        report_mismatch("roll", i_result.roll_angle, want.roll_angle);
                    if (i_result.yaw_angle !== want.yaw_angle)
                        report_mismatch("yaw", i_result.yaw_angle, want.yaw_angle);
                end
            end
        end
        o_pending <= angle_fifo.size();
    end

    initial o_fail_count = 0;
endmodule

// ===== bench/imu_complementary_attitude_filter_tb.sv =====
// Testbench top for the attitude filter: stimulus, register setup and verdict.
module imu_complementary_attitude_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import imu_caf_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_imu_in     i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_imu_out    o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          drain_stalls = 1'b1;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    imu_complementary_attitude_filter u_dut (
        .i_clk, .i_rst_n, .push, .full, .i_item, .empty, .pop, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    imu_caf_checker u_checker (
        .i_clk, .i_rst_n, .i_push(push), .i_full(full), .i_item, .i_empty(empty),
        .i_pop(pop), .i_result(o_result), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Mostly short gaps, now and then a long one; none at all in some stretches.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Result side: pop with random stalls while drain_stalls is set, else always; changed on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else if (drain_stalls)
            pop <= ($urandom_range(99) < 60);
        else
            pop <= 1'b1;
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[imu_complementary_attitude_filter] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // After a random gap with push low, hold push until the transfer happens.
    task automatic send_sample(input t_imu_in s);
        int g;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_item <= s;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // Drop push right away so the last sample is not sent twice.
    task automatic wait_drained();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7fff;
        if (r == 2) return 16'h0000;
        if (r == 3) return 16'($signed($urandom_range(0, 40)) - 20);
        return 16'($urandom);
    endfunction

    function automatic t_imu_in rand_sample();
        t_imu_in s;
        s.accel_x = pick16();
        s.accel_y = pick16();
        s.accel_z = pick16();
        s.gyro_x  = pick16();
        s.gyro_y  = pick16();
        s.gyro_z  = pick16();
        return s;
    endfunction

    task automatic random_phase(input int n);
        repeat (n) send_sample(rand_sample());
    endtask

    initial begin
        t_imu_in s;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero vector, sign corners of atan2, field extremes.
        send_sample('0);
        send_sample('{0, 0, -16384, 0, 0, 0});             // negative denominator, zero numerator
        send_sample('{100, -100, -16384, 0, 0, 0});        // negative denominator both signs
        send_sample('{-32768, 32767, -32768, 32767, -32768, 32767});
        send_sample('{32767, -32768, 32767, -32768, 32767, -32768});
        send_sample('{0, 16384, 0, 5, -5, 1000});          // zero denominator
        send_sample('{-16384, -16384, 1, 0, 0, 0});
        send_sample('{1, 1, 16384, 16'h00ff, 16'h00ff, 16'h00ff});
        send_sample('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
        random_phase(40);
        wait_drained();

        // Pure gyro path, huge gains: drive the stores into saturation both ways.
        write_reg(REG_ACCEL_WEIGHT, 32'd0);
        write_reg(REG_TILT_GAIN, 32'hffff_ffff);
        write_reg(REG_YAW_GAIN, 32'hffff_ffff);
        write_reg(REG_YAW_BIAS, 32'h8000_0000);
        repeat (6) send_sample('{0, 0, 0, 32767, 32767, 32767});
        repeat (6) send_sample('{0, 0, 0, -32768, -32768, -32768});
        random_phase(60);
        wait_drained();

        // Weight above one is clamped; full-scale weight; bias at its top.
        write_reg(REG_ACCEL_WEIGHT, 32'h0001_ffff);
        write_reg(REG_TILT_GAIN, 32'd0);
        write_reg(REG_YAW_GAIN, 32'd0);
        write_reg(REG_YAW_BIAS, 32'h7fff_ffff);
        send_sample('{0, 0, -1, 0, 0, 0});
        random_phase(50);
        wait_drained();
        write_reg(REG_ACCEL_WEIGHT, 32'd65536);
        random_phase(40);
        wait_drained();

        // Back to reset values, then a run with pop held high; the bus decodes 2 bits.
        write_reg(REG_ACCEL_WEIGHT, 32'd1311);
        write_reg(REG_TILT_GAIN, 32'd1309441);
        write_reg(REG_YAW_GAIN, 32'd1309441);
        write_reg(REG_YAW_BIAS, 32'd0);
        drain_stalls = 1'b0;
        random_phase(120);
        drain_stalls = 1'b1;
        wait_drained();

        // Random settings, weight at times above one.
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_ACCEL_WEIGHT, $urandom_range(0, 70000));
            write_reg(REG_TILT_GAIN, $urandom);
            write_reg(REG_YAW_GAIN, $urandom_range(0, 1 << 24));
            write_reg(REG_YAW_BIAS, $urandom);
            random_phase(60);
            wait_drained();
        end

        if (fail_count == 0)
            $display("[imu_complementary_attitude_filter] OK");
        else
            $display("[imu_complementary_attitude_filter] ERROR");
        $finish;
    end
endmodule
